// ===== hdl/spcio_pkg.sv =====
// shared types, address map, timer constants and boot rom contents for the sound cpu i/o page
package spcio_pkg;

    localparam int MAX_TIMERS     = 3;
    localparam int NUM_TIMERS_DEF = 3;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_CPU_READ   = 3'd1,
        OP_CPU_WRITE  = 3'd2,
        OP_HOST_WRITE = 3'd3,
        OP_HOST_READ  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        EXT_NONE      = 3'd0,
        EXT_RAM_READ  = 3'd1,
        EXT_RAM_WRITE = 3'd2,
        EXT_DSP_READ  = 3'd3,
        EXT_DSP_WRITE = 3'd4
    } ext_kind_t;

    localparam logic [15:0] ADDR_TEST      = 16'h00f0;
    localparam logic [15:0] ADDR_CONTROL   = 16'h00f1;
    localparam logic [15:0] ADDR_DSP_INDEX = 16'h00f2;
    localparam logic [15:0] ADDR_DSP_DATA  = 16'h00f3;
    localparam logic [15:0] ADDR_PORT0     = 16'h00f4;
    localparam logic [15:0] ADDR_PORT3     = 16'h00f7;
    localparam logic [15:0] ADDR_AUX0      = 16'h00f8;
    localparam logic [15:0] ADDR_AUX1      = 16'h00f9;
    localparam logic [15:0] ADDR_TARGET0   = 16'h00fa;
    localparam logic [15:0] ADDR_TARGET2   = 16'h00fc;
    localparam logic [15:0] ADDR_COUNTER0  = 16'h00fd;
    localparam logic [15:0] ADDR_COUNTER2  = 16'h00ff;
    localparam logic [15:0] ROM_BASE       = 16'hffc0;

    localparam logic [7:0] DSP_INDEX_MASK = 8'h7f;

    // control register bit positions
    localparam int CTRL_CLEAR_PORTS01 = 4;
    localparam int CTRL_CLEAR_PORTS23 = 5;
    localparam int CTRL_ROM_ON        = 7;

    localparam logic [7:0] PRESCALE_SLOW = 8'd128;
    localparam logic [7:0] PRESCALE_FAST = 8'd16;

    typedef struct packed {
        logic tick;
        logic ctrl_wr;
        logic enable;
        logic target_wr;
        logic count_rd;
    } timer_cmd_t;

    localparam logic [7:0] BOOT_ROM [64] = '{
        8'hcd, 8'hef, 8'hbd, 8'he8, 8'h00, 8'hc6, 8'h1d, 8'hd0,
        8'hfc, 8'h8f, 8'haa, 8'hf4, 8'h8f, 8'hbb, 8'hf5, 8'h78,
        8'hcc, 8'hf4, 8'hd0, 8'hfb, 8'h2f, 8'h19, 8'heb, 8'hf4,
        8'hd0, 8'hfc, 8'h7e, 8'hf4, 8'hd0, 8'h0b, 8'he4, 8'hf5,
        8'hcb, 8'hf4, 8'hd7, 8'h00, 8'hfc, 8'hd0, 8'hf3, 8'hab,
        8'h01, 8'h10, 8'hef, 8'h7e, 8'hf4, 8'h10, 8'heb, 8'hba,
        8'hf6, 8'hda, 8'h00, 8'hba, 8'hf4, 8'hc4, 8'hf4, 8'hdd,
        8'h5d, 8'hd0, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
    };

    function automatic logic [7:0] boot_rom_byte(input logic [5:0] a);
        return BOOT_ROM[a];
    endfunction

    // the third timer runs from the fast prescaler
    function automatic logic [7:0] prescale_period(input int t);
        return (t == 2) ? PRESCALE_FAST : PRESCALE_SLOW;
    endfunction

endpackage

// ===== hdl/spcio_timer.sv =====
// one timer: prescaler, 8-bit divider with target and 4-bit read-to-clear counter
module spcio_timer #(
    parameter logic [7:0] PRESCALE = spcio_pkg::PRESCALE_SLOW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spcio_pkg::timer_cmd_t  cmd,
    input  logic [7:0]             data,
    output logic [3:0]             count
);
    import spcio_pkg::*;

    logic [7:0] prescale_reg, prescale_next;
    logic [7:0] divide_reg, divide_next;
    logic [7:0] target_reg, target_next;
    logic [3:0] count_reg, count_next;
    logic       enable_reg, enable_next;
    logic [7:0] divide_inc;

    always_comb
    begin
        prescale_next = prescale_reg;
        divide_next   = divide_reg;
        target_next   = target_reg;
        count_next    = count_reg;
        enable_next   = enable_reg;
        divide_inc    = divide_reg + 8'd1;

        if (cmd.tick)
        begin
            if (prescale_reg == 8'd0)
            begin
                prescale_next = PRESCALE - 8'd1;
                if (enable_reg)
                begin
                    // target of zero matches after 256 steps through the wrap
                    if (divide_inc == target_reg)
                    begin
                        divide_next = 8'd0;
                        count_next  = count_reg + 4'd1;
                    end
                    else
                    begin
                        divide_next = divide_inc;
                    end
                end
            end
            else
            begin
                prescale_next = prescale_reg - 8'd1;
            end
        end

        if (cmd.ctrl_wr)
        begin
            if (!enable_reg && cmd.enable)
            begin
                divide_next = 8'd0;
                count_next  = 4'd0;
            end
            enable_next = cmd.enable;
        end

        if (cmd.target_wr)
        begin
            target_next = data;
        end

        if (cmd.count_rd)
        begin
            count_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 8'd0;
            divide_reg   <= 8'd0;
            target_reg   <= 8'd0;
            count_reg    <= 4'd0;
            enable_reg   <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            divide_reg   <= divide_next;
            target_reg   <= target_next;
            count_reg    <= count_next;
            enable_reg   <= enable_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== hdl/sound_cpu_timers_and_io_ports.sv =====
// top level of the sound cpu i/o page: decode, ports, dsp index and result register
// Usage
//   Input channel (in_valid/in_stall) carries one transaction per item: op, addr, data.
//   op selects a tick, a cpu read, a cpu write, a host port write or a host port read.
//   Output channel (out_valid/out_stall) returns exactly one result per input transaction:
//   read_data for reads served here, an external ram/dsp request in ext_kind/ext_addr/
//   ext_data, and dsp_tick on every 32nd tick.
//   The result reaches the output register in the cycle after acceptance.
//   Throughput is 1 item per cycle while in_stall is low: state updates and result decode are
//   done in the accepting cycle and the result is held in one output register.
//   in_stall is raised only while a result sits in the output register and out_stall is
//   high; the held result does not change until it is taken.
//   Reset (rst_n low, asynchronous) clears the timers, ports, dsp index and cycle phase,
//   enables the boot rom and empties the output register. No clearing pass is needed.
//   NUM_TIMERS (1..3) sets how many timers exist; missing timers read 0 and ignore writes.
module sound_cpu_timers_and_io_ports #(
    parameter int NUM_TIMERS = spcio_pkg::NUM_TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [15:0] addr,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [2:0]  ext_kind,
    output logic [15:0] ext_addr,
    output logic [7:0]  ext_data,
    output logic        dsp_tick
);
    import spcio_pkg::*;

    logic        accept;
    logic        is_tick, is_cpu_read, is_cpu_write;

    logic [7:0]  dsp_index_reg, dsp_index_next;
    logic [4:0]  cycle_phase_reg, cycle_phase_next;
    logic [7:0]  port_in_reg [6];
    logic [7:0]  port_in_next [6];
    logic [7:0]  port_out_reg [4];
    logic [7:0]  port_out_next [4];
    logic        boot_rom_on_reg, boot_rom_on_next;

    timer_cmd_t  timer_cmd [NUM_TIMERS];
    logic [3:0]  timer_count [NUM_TIMERS];
    logic [3:0]  counter_rd;
    logic [2:0]  pin_idx;

    logic [7:0]  rd;
    ext_kind_t   kind;
    logic [15:0] eaddr;
    logic [7:0]  edata;
    logic        dtick;

    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic [2:0]  ext_kind_reg;
    logic [15:0] ext_addr_reg;
    logic [7:0]  ext_data_reg;
    logic        dsp_tick_reg;

    assign in_stall     = out_valid_reg && out_stall;
    assign accept       = in_valid && !in_stall;
    assign is_tick      = (op == OP_TICK);
    assign is_cpu_read  = (op == OP_CPU_READ);
    assign is_cpu_write = (op == OP_CPU_WRITE);

    // ports f4..f9 map to port_in entries 0..5
    assign pin_idx = 3'(addr[3:0] - 4'd4);

    // timers
    always_comb
    begin
        counter_rd = 4'd0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            timer_cmd[i].tick      = accept && is_tick;
            timer_cmd[i].ctrl_wr   = accept && is_cpu_write && (addr == ADDR_CONTROL);
            timer_cmd[i].enable    = data[i];
            timer_cmd[i].target_wr = accept && is_cpu_write && (addr == ADDR_TARGET0 + 16'(i));
            timer_cmd[i].count_rd  = accept && is_cpu_read && (addr == ADDR_COUNTER0 + 16'(i));
            if (addr == ADDR_COUNTER0 + 16'(i))
            begin
                counter_rd = timer_count[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_timer
        spcio_timer #(
            .PRESCALE (prescale_period(g))
        ) u_timer (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (timer_cmd[g]),
            .data  (data),
            .count (timer_count[g])
        );
    end

    // result decode and state updates for the item on the input
    always_comb
    begin
        rd               = 8'd0;
        kind             = EXT_NONE;
        eaddr            = 16'd0;
        edata            = 8'd0;
        dtick            = 1'b0;
        dsp_index_next   = dsp_index_reg;
        cycle_phase_next = cycle_phase_reg;
        port_in_next     = port_in_reg;
        port_out_next    = port_out_reg;
        boot_rom_on_next = boot_rom_on_reg;

        case (op)
            OP_TICK:
            begin
                dtick            = (cycle_phase_reg == 5'd0);
                cycle_phase_next = cycle_phase_reg + 5'd1;
            end
            OP_CPU_READ:
            begin
                if (addr == ADDR_TEST || addr == ADDR_CONTROL ||
                    (addr >= ADDR_TARGET0 && addr <= ADDR_TARGET2))
                begin
                    rd = 8'd0;
                end
                else if (addr == ADDR_DSP_INDEX)
                begin
                    rd = dsp_index_reg;
                end
                else if (addr == ADDR_DSP_DATA)
                begin
                    kind  = EXT_DSP_READ;
                    eaddr = {8'd0, dsp_index_reg & DSP_INDEX_MASK};
                end
                else if (addr >= ADDR_PORT0 && addr <= ADDR_AUX1)
                begin
                    rd = port_in_reg[pin_idx];
                end
                else if (addr >= ADDR_COUNTER0 && addr <= ADDR_COUNTER2)
                begin
                    rd = {4'd0, counter_rd};
                end
                else if (boot_rom_on_reg && addr >= ROM_BASE)
                begin
                    rd = boot_rom_byte(addr[5:0]);
                end
                else
                begin
                    kind  = EXT_RAM_READ;
                    eaddr = addr;
                end
            end
            OP_CPU_WRITE:
            begin
                // every cpu write shadows into ram unless it becomes a dsp write
                kind  = EXT_RAM_WRITE;
                eaddr = addr;
                edata = data;
                if (addr == ADDR_CONTROL)
                begin
                    if (data[CTRL_CLEAR_PORTS01])
                    begin
                        port_in_next[0] = 8'd0;
                        port_in_next[1] = 8'd0;
                    end
                    if (data[CTRL_CLEAR_PORTS23])
                    begin
                        port_in_next[2] = 8'd0;
                        port_in_next[3] = 8'd0;
                    end
                    boot_rom_on_next = data[CTRL_ROM_ON];
                end
                else if (addr == ADDR_DSP_INDEX)
                begin
                    dsp_index_next = data;
                end
                else if (addr == ADDR_DSP_DATA)
                begin
                    if (!dsp_index_reg[7])
                    begin
                        kind  = EXT_DSP_WRITE;
                        eaddr = {8'd0, dsp_index_reg};
                    end
                end
                else if (addr >= ADDR_PORT0 && addr <= ADDR_PORT3)
                begin
                    port_out_next[addr[1:0]] = data;
                end
                else if (addr == ADDR_AUX0 || addr == ADDR_AUX1)
                begin
                    port_in_next[pin_idx] = data;
                end
            end
            OP_HOST_WRITE:
            begin
                port_in_next[{1'b0, addr[1:0]}] = data;
            end
            OP_HOST_READ:
            begin
                rd = port_out_reg[addr[1:0]];
            end
            default:
            begin
                rd = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsp_index_reg   <= 8'd0;
            cycle_phase_reg <= 5'd0;
            boot_rom_on_reg <= 1'b1;
            for (int i = 0; i < 6; i++)
            begin
                port_in_reg[i] <= 8'd0;
            end
            for (int i = 0; i < 4; i++)
            begin
                port_out_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            dsp_index_reg   <= dsp_index_next;
            cycle_phase_reg <= cycle_phase_next;
            boot_rom_on_reg <= boot_rom_on_next;
            port_in_reg     <= port_in_next;
            port_out_reg    <= port_out_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= rd;
            ext_kind_reg  <= kind;
            ext_addr_reg  <= eaddr;
            ext_data_reg  <= edata;
            dsp_tick_reg  <= dtick;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign ext_kind  = ext_kind_reg;
    assign ext_addr  = ext_addr_reg;
    assign ext_data  = ext_data_reg;
    assign dsp_tick  = dsp_tick_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted transaction did not produce a result");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_tick |=> cycle_phase_reg == 5'($past(cycle_phase_reg) + 5'd1))
        else $error("cycle phase did not advance on tick");

    a_dsp_tick_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dsp_tick |-> ext_kind == EXT_NONE && read_data == 8'd0)
        else $error("dsp tick result carries other fields");

    a_dsp_write_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ext_kind == EXT_DSP_WRITE |-> !ext_addr[7] && ext_addr[15:8] == 8'd0)
        else $error("dsp write with index at or above 0x80");

    a_rom_off: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_cpu_write && addr == ADDR_CONTROL && !data[CTRL_ROM_ON]
        |=> !boot_rom_on_reg)
        else $error("boot rom still mapped after control write cleared it");

endmodule

// ===== test/tb_sound_cpu_timers_and_io_ports.sv =====
// self-checking testbench for the sound cpu i/o page: timers, ports, dsp register pair and boot rom
module tb_sound_cpu_timers_and_io_ports;
    timeunit 1ns;
    timeprecision 1ps;

    import spcio_pkg::*;

    localparam int TIMER_COUNT = NUM_TIMERS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // ops past the last defined one must leave the block untouched
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    localparam logic [7:0] BOOT_IMAGE [64] = '{
        8'hcd, 8'hef, 8'hbd, 8'he8, 8'h00, 8'hc6, 8'h1d, 8'hd0,
        8'hfc, 8'h8f, 8'haa, 8'hf4, 8'h8f, 8'hbb, 8'hf5, 8'h78,
        8'hcc, 8'hf4, 8'hd0, 8'hfb, 8'h2f, 8'h19, 8'heb, 8'hf4,
        8'hd0, 8'hfc, 8'h7e, 8'hf4, 8'hd0, 8'h0b, 8'he4, 8'hf5,
        8'hcb, 8'hf4, 8'hd7, 8'h00, 8'hfc, 8'hd0, 8'hf3, 8'hab,
        8'h01, 8'h10, 8'hef, 8'h7e, 8'hf4, 8'h10, 8'heb, 8'hba,
        8'hf6, 8'hda, 8'h00, 8'hba, 8'hf4, 8'hc4, 8'hf4, 8'hdd,
        8'h5d, 8'hd0, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
    };

    typedef struct {
        logic [7:0]  read_data;
        ext_kind_t   kind;
        logic [15:0] ext_addr;
        logic [7:0]  ext_data;
        logic        dsp_tick;
    } bus_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = '0;
    logic [15:0] addr = '0;
    logic [7:0]  data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic [2:0]  ext_kind;
    logic [15:0] ext_addr;
    logic [7:0]  ext_data;
    logic        dsp_tick;

    // predicted state of the i/o page
    logic [7:0] pre_cnt [MAX_TIMERS];
    logic [7:0] div_cnt [MAX_TIMERS];
    logic [7:0] div_tgt [MAX_TIMERS];
    logic [3:0] tmr_cnt [MAX_TIMERS];
    logic       tmr_en [MAX_TIMERS];
    logic [7:0] dsp_reg;
    logic [4:0] phase;
    logic [7:0] in_ports [6];
    logic [7:0] out_ports [4];
    logic       rom_enabled;

    bus_result_t pending_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_active = 1'b0;
    event        receiver_hold;

    sound_cpu_timers_and_io_ports dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .addr      (addr),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data),
        .ext_kind  (ext_kind),
        .ext_addr  (ext_addr),
        .ext_data  (ext_data),
        .dsp_tick  (dsp_tick)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_model();
        for (int t = 0; t < MAX_TIMERS; t++)
        begin
            pre_cnt[t] = '0;
            div_cnt[t] = '0;
            div_tgt[t] = '0;
            tmr_cnt[t] = '0;
            tmr_en[t] = 1'b0;
        end
        foreach (in_ports[i]) in_ports[i] = '0;
        foreach (out_ports[i]) out_ports[i] = '0;
        dsp_reg = '0;
        phase = '0;
        rom_enabled = 1'b1;
    endfunction

    function automatic void advance_timers();
        for (int t = 0; t < TIMER_COUNT; t++)
        begin
            if (pre_cnt[t] == 8'd0)
            begin
                pre_cnt[t] = (t == 2) ? PRESCALE_FAST : PRESCALE_SLOW;
                if (tmr_en[t])
                begin
                    // an 8-bit wrap to zero matches a target of zero, i.e. 256 steps
                    div_cnt[t] = div_cnt[t] + 8'd1;
                    if (div_cnt[t] == div_tgt[t])
                    begin
                        div_cnt[t] = '0;
                        tmr_cnt[t] = tmr_cnt[t] + 4'd1;
                    end
                end
            end
            pre_cnt[t] = pre_cnt[t] - 8'd1;
        end
        phase = phase + 5'd1;
    endfunction

    function automatic bus_result_t predict_bus_access(input logic [2:0] o,
                                                      input logic [15:0] a,
                                                      input logic [7:0] d);
        bus_result_t r;
        int idx;
        r.read_data = '0;
        r.kind = EXT_NONE;
        r.ext_addr = '0;
        r.ext_data = '0;
        r.dsp_tick = 1'b0;
        case (o)
            OP_TICK:
            begin
                r.dsp_tick = (phase == 5'd0);
                advance_timers();
            end
            OP_CPU_READ:
            begin
                if (a == ADDR_TEST || a == ADDR_CONTROL || (a >= ADDR_TARGET0 && a <= ADDR_TARGET2))
                    r.read_data = '0;
                else if (a == ADDR_DSP_INDEX)
                    r.read_data = dsp_reg;
                else if (a == ADDR_DSP_DATA)
                begin
                    r.kind = EXT_DSP_READ;
                    r.ext_addr = {8'h00, dsp_reg & DSP_INDEX_MASK};
                end
                else if (a >= ADDR_PORT0 && a <= ADDR_AUX1)
                    r.read_data = in_ports[int'(a - ADDR_PORT0)];
                else if (a >= ADDR_COUNTER0 && a <= ADDR_COUNTER2)
                begin
                    idx = int'(a - ADDR_COUNTER0);
                    if (idx < TIMER_COUNT)
                    begin
                        r.read_data = {4'h0, tmr_cnt[idx]};
                        tmr_cnt[idx] = '0;
                    end
                end
                else if (rom_enabled && a >= ROM_BASE)
                    r.read_data = BOOT_IMAGE[a[5:0]];
                else
                begin
                    r.kind = EXT_RAM_READ;
                    r.ext_addr = a;
                end
            end
            OP_CPU_WRITE:
            begin
                // every cpu write shadows into ram unless it reaches the dsp
                r.kind = EXT_RAM_WRITE;
                r.ext_addr = a;
                r.ext_data = d;
                if (a == ADDR_CONTROL)
                begin
                    for (int t = 0; t < TIMER_COUNT; t++)
                    begin
                        if (!tmr_en[t] && d[t])
                        begin
                            div_cnt[t] = '0;
                            tmr_cnt[t] = '0;
                        end
                        tmr_en[t] = d[t];
                    end
                    if (d[CTRL_CLEAR_PORTS01])
                    begin
                        in_ports[0] = '0;
                        in_ports[1] = '0;
                    end
                    if (d[CTRL_CLEAR_PORTS23])
                    begin
                        in_ports[2] = '0;
                        in_ports[3] = '0;
                    end
                    rom_enabled = d[CTRL_ROM_ON];
                end
                else if (a == ADDR_DSP_INDEX)
                    dsp_reg = d;
                else if (a == ADDR_DSP_DATA)
                begin
                    if (dsp_reg[7] == 1'b0)
                    begin
                        r.kind = EXT_DSP_WRITE;
                        r.ext_addr = {8'h00, dsp_reg};
                    end
                end
                else if (a >= ADDR_PORT0 && a <= ADDR_PORT3)
                    out_ports[int'(a - ADDR_PORT0)] = d;
                else if (a == ADDR_AUX0 || a == ADDR_AUX1)
                    in_ports[int'(a - ADDR_PORT0)] = d;
                else if (a >= ADDR_TARGET0 && a <= ADDR_TARGET2)
                begin
                    idx = int'(a - ADDR_TARGET0);
                    if (idx < TIMER_COUNT)
                        div_tgt[idx] = d;
                end
            end
            OP_HOST_WRITE: in_ports[{1'b0, a[1:0]}] = d;
            OP_HOST_READ: r.read_data = out_ports[a[1:0]];
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            note_error($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
    endtask

    // result channel: compare each transaction against the oldest prediction
    always @(posedge clk)
    begin
        bus_result_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                note_error("result transaction with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", 16'(want.read_data), 16'(read_data));
                check_field("ext_kind", 16'(want.kind), 16'(ext_kind));
                check_field("ext_addr", want.ext_addr, ext_addr);
                check_field("ext_data", 16'(want.ext_data), 16'(ext_data));
                check_field("dsp_tick", 16'(want.dsp_tick), 16'(dsp_tick));
            end
        end
        out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end

    // long receiver hold-off, counted here
    always
    begin
        @(receiver_hold);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_bus_item(input logic [2:0] o, input logic [15:0] a, input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        addr <= a;
        data <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(predict_bus_access(o, a, d));
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_cpu_address();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return ADDR_TEST + 16'($urandom_range(15));
        if (sel < 70)
            return ROM_BASE + 16'($urandom_range(63));
        return 16'($urandom_range(65535));
    endfunction

    task automatic send_random_item(input int tick_pct);
        int unsigned pick;
        logic [2:0] o;
        logic [15:0] a;
        logic [7:0] d;
        a = 16'($urandom_range(65535));
        d = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < tick_pct)
            o = OP_TICK;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                o = OP_CPU_READ;
            else if (pick < 75)
                o = OP_CPU_WRITE;
            else if (pick < 85)
                o = OP_HOST_WRITE;
            else if (pick < 95)
                o = OP_HOST_READ;
            else
                o = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            if (o == OP_CPU_READ || o == OP_CPU_WRITE)
                a = pick_cpu_address();
        end
        send_bus_item(o, a, d);
    endtask

    task automatic test_directed();
        // boot rom is mapped after reset
        send_bus_item(OP_CPU_READ, ROM_BASE, 8'h00);
        send_bus_item(OP_CPU_READ, 16'hffff, 8'hff);
        // the first tick carries the dsp tick
        send_bus_item(OP_TICK, 16'h0000, 8'h00);
        send_bus_item(OP_TICK, 16'hffff, 8'hff);
        send_bus_item(OP_CPU_WRITE, ADDR_DSP_INDEX, 8'h7f);
        send_bus_item(OP_CPU_WRITE, ADDR_DSP_DATA, 8'hab);
        send_bus_item(OP_CPU_READ, ADDR_DSP_DATA, 8'h00);
        // index with the top bit set: data write only shadows to ram
        send_bus_item(OP_CPU_WRITE, ADDR_DSP_INDEX, 8'hff);
        send_bus_item(OP_CPU_WRITE, ADDR_DSP_DATA, 8'h55);
        send_bus_item(OP_CPU_READ, ADDR_DSP_DATA, 8'h00);
        send_bus_item(OP_CPU_READ, ADDR_DSP_INDEX, 8'h00);
        send_bus_item(OP_CPU_READ, ADDR_TEST, 8'h00);
        send_bus_item(OP_CPU_READ, ADDR_CONTROL, 8'h00);
        send_bus_item(OP_CPU_READ, ADDR_TARGET2, 8'h00);
        // host port number wider than two bits
        send_bus_item(OP_HOST_WRITE, 16'hffff, 8'hff);
        send_bus_item(OP_CPU_READ, ADDR_PORT3, 8'h00);
        send_bus_item(OP_HOST_WRITE, 16'h0000, 8'h5a);
        send_bus_item(OP_CPU_WRITE, ADDR_PORT0, 8'hc3);
        send_bus_item(OP_HOST_READ, 16'h0004, 8'h00);
        send_bus_item(OP_CPU_WRITE, ADDR_AUX1, 8'h12);
        send_bus_item(OP_CPU_READ, ADDR_AUX1, 8'h00);
        // all timers on, both port pairs cleared, rom unmapped
        send_bus_item(OP_CPU_WRITE, ADDR_CONTROL, 8'h37);
        send_bus_item(OP_CPU_READ, ADDR_PORT0, 8'h00);
        send_bus_item(OP_CPU_READ, 16'hffff, 8'h00);
        send_bus_item(OP_CPU_READ, ADDR_COUNTER2, 8'h00);
        send_bus_item(OP_RESERVED_HI, 16'hffff, 8'hff);
        wait_until_drained();
    endtask

    task automatic test_mixed_traffic(input int count);
        repeat (count) send_random_item(35);
        wait_until_drained();
    endtask

    task automatic test_timer_run(input int count);
        int unsigned pick;
        logic [7:0] ctrl;
        // short targets for timers 0 and 2 so their counters move within the run; timer 1 gets a target of zero
        send_bus_item(OP_CPU_WRITE, ADDR_TARGET0, 8'd1);
        send_bus_item(OP_CPU_WRITE, ADDR_TARGET0 + 16'd1, 8'd0);
        send_bus_item(OP_CPU_WRITE, ADDR_TARGET2, 8'd1);
        send_bus_item(OP_CPU_WRITE, ADDR_CONTROL, 8'h87);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 82)
                send_bus_item(OP_TICK, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            else if (pick < 88)
                send_bus_item(OP_CPU_READ, ADDR_COUNTER0 + 16'($urandom_range(2)), 8'h00);
            else if (pick < 92)
                send_bus_item(OP_CPU_WRITE, ADDR_TARGET0 + 16'($urandom_range(2)),
                              8'($urandom_range(3)));
            else if (pick < 94)
            begin
                ctrl = 8'($urandom_range(255));
                if ($urandom_range(3) != 0)
                    ctrl[2:0] = '1;
                send_bus_item(OP_CPU_WRITE, ADDR_CONTROL, ctrl);
            end
            else
                send_random_item(0);
        end
        wait_until_drained();
    endtask

    task automatic test_output_hold(input int count);
        -> receiver_hold;
        repeat (count) send_random_item(40);
        wait_until_drained();
    endtask

    initial
    begin
        clear_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 77;
        test_directed();
        test_mixed_traffic(220);

        send_idle_pct = 77;
        recv_idle_pct = 15;
        test_timer_run(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed_traffic(220);
        test_output_hold(30);

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/spcio_pkg.sv
hdl/spcio_timer.sv
hdl/sound_cpu_timers_and_io_ports.sv
test/tb_sound_cpu_timers_and_io_ports.sv
